[rtl/core/oed_pkg.sv]
package oed_pkg;

    localparam int unsigned MaxOut = 5;

    localparam logic [7:0] CHAR_BSL = 8'h5C;

    // Upper bits shared by all octal digit characters and by '0' and '1'.
    localparam logic [4:0] OCT_PREFIX = 5'b00110;
    localparam logic [6:0] BIN_PREFIX = 7'b0011000;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_BSL,
        PH_HIGH,
        PH_MID
    } t_phase;

    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [2:0]             cnt;
        logic                   fin;
        t_phase                 phase;
        logic                   hi;
        logic [2:0]             mid;
    } t_dec_res;

endpackage

[rtl/core/oed_decode.sv]
module oed_decode (
    input  logic [7:0]        i_byte,
    input  logic              i_fin,
    input  oed_pkg::t_phase   i_phase,
    input  logic              i_hi,
    input  logic [2:0]        i_mid,
    output oed_pkg::t_dec_res o_res
);
    import oed_pkg::*;

    logic is_bsl;
    logic is_oct;
    logic is_bin;

    assign is_bsl = (i_byte == CHAR_BSL);
    assign is_oct = (i_byte[7:3] == OCT_PREFIX);
    assign is_bin = (i_byte[7:1] == BIN_PREFIX);

    always_comb begin
        logic [MaxOut-1:0][7:0] list;
        logic [2:0]             cnt;
        t_phase                 ph;
        logic                   hi;
        logic [2:0]             mid;

        list = '0;
        cnt  = 3'd0;
        ph   = i_phase;
        hi   = i_hi;
        mid  = i_mid;

        case (i_phase)
            PH_PLAIN: begin
                if (is_bsl) begin
                    ph = PH_BSL;
                end else begin
                    list[cnt] = i_byte;
                    cnt = cnt + 3'd1;
                end
            end
            PH_BSL: begin
                if (is_bin) begin
                    hi = i_byte[0];
                    ph = PH_HIGH;
                end else begin
                    list[cnt] = CHAR_BSL;
                    cnt = cnt + 3'd1;
                    if (!is_bsl) begin
                        list[cnt] = i_byte;
                        cnt = cnt + 3'd1;
                    end
                    ph = PH_PLAIN;
                end
            end
            PH_HIGH: begin
                if (is_oct) begin
                    mid = i_byte[2:0];
                    ph  = PH_MID;
                end else begin
                    list[cnt] = CHAR_BSL;
                    cnt = cnt + 3'd1;
                    list[cnt] = {BIN_PREFIX, i_hi};
                    cnt = cnt + 3'd1;
                    if (is_bsl) begin
                        ph = PH_BSL;
                    end else begin
                        list[cnt] = i_byte;
                        cnt = cnt + 3'd1;
                        ph = PH_PLAIN;
                    end
                end
            end
            PH_MID: begin
                if (is_oct) begin
                    list[cnt] = {1'b0, i_hi, i_mid, i_byte[2:0]};
                    cnt = cnt + 3'd1;
                    ph  = PH_PLAIN;
                end else begin
                    list[cnt] = CHAR_BSL;
                    cnt = cnt + 3'd1;
                    list[cnt] = {BIN_PREFIX, i_hi};
                    cnt = cnt + 3'd1;
                    list[cnt] = {OCT_PREFIX, i_mid};
                    cnt = cnt + 3'd1;
                    if (is_bsl) begin
                        ph = PH_BSL;
                    end else begin
                        list[cnt] = i_byte;
                        cnt = cnt + 3'd1;
                        ph = PH_PLAIN;
                    end
                end
            end
            default: begin
                ph = PH_PLAIN;
            end
        endcase

        // The last byte of a string flushes whatever is still held.
        if (i_fin) begin
            if (ph != PH_PLAIN) begin
                list[cnt] = CHAR_BSL;
                cnt = cnt + 3'd1;
            end
            if (ph == PH_HIGH || ph == PH_MID) begin
                list[cnt] = {BIN_PREFIX, hi};
                cnt = cnt + 3'd1;
            end
            if (ph == PH_MID) begin
                list[cnt] = {OCT_PREFIX, mid};
                cnt = cnt + 3'd1;
            end
            ph = PH_PLAIN;
        end

        o_res.bytes = list;
        o_res.cnt   = cnt;
        o_res.fin   = i_fin;
        o_res.phase = ph;
        o_res.hi    = hi;
        o_res.mid   = mid;
    end

endmodule

[rtl/core/oed_out_buf.sv]
module oed_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  oed_pkg::t_dec_res i_res,
    output logic              o_free,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,  // out_byte
    output logic              o_m_tlast,
    output logic              o_m_tuser   // string_end
);
    import oed_pkg::*;

    logic [MaxOut-1:0][7:0] r_buf;
    logic [2:0]             r_idx;
    logic [2:0]             r_left;
    logic                   r_fin;
    logic                   out_hs;

    assign out_hs     = o_m_tvalid && i_m_tready;
    assign o_free     = (r_left == 3'd0) || ((r_left == 3'd1) && i_m_tready);
    assign o_m_tvalid = (r_left != 3'd0);
    assign o_m_tdata  = r_buf[r_idx];
    assign o_m_tlast  = (r_left == 3'd1);
    assign o_m_tuser  = (r_left == 3'd1) && r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_idx  <= 3'd0;
        end else if (i_load) begin
            r_left <= i_res.cnt;
            r_idx  <= 3'd0;
        end else if (out_hs) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res.bytes;
            r_fin <= i_res.fin;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(MaxOut))
        else $error("result count out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free && (i_res.cnt != 3'd0))
        else $error("buffer loaded while busy or with no words");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && !i_load) |=> (r_left == $past(r_left) - 3'd1))
        else $error("buffer did not advance on handshake");

endmodule

[rtl/core/octal_escape_decoder_unit.sv]
// Channel   Dir  tdata           tlast       tuser
// s (in)    in   in_byte [7:0]   is_final    -
// m (out)   out  out_byte [7:0]  run_last    string_end
//
// An input word is registered, decoded combinationally into up to four
// output words, and those words drain from a result buffer one per cycle
// while the output is ready. A word that yields zero or one output word
// sustains one word per cycle while the output is ready; a word that yields
// more holds the input side while the result buffer drains.
// Reset is synchronous and active low; it returns the decoder to plain text.
module octal_escape_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // out_byte
    output logic       o_m_tlast,
    output logic       o_m_tuser   // string_end
);
    import oed_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fin;
    t_phase     r_phase;
    logic       r_hi;
    logic [2:0] r_mid;

    t_dec_res   dec;
    logic       buf_free;
    logic       consume;
    logic       load;

    oed_decode u_decode (
        .i_byte  (r_in_byte),
        .i_fin   (r_in_fin),
        .i_phase (r_phase),
        .i_hi    (r_hi),
        .i_mid   (r_mid),
        .o_res   (dec)
    );

    assign consume    = r_in_valid && ((dec.cnt == 3'd0) || buf_free);
    assign load       = consume && (dec.cnt != 3'd0);
    assign o_s_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_fin  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_hi    <= 1'b0;
            r_mid   <= 3'd0;
        end else if (consume) begin
            r_phase <= dec.phase;
            r_hi    <= dec.hi;
            r_mid   <= dec.mid;
        end
    end

    oed_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (dec),
        .o_free     (buf_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    a_final_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_fin) |=> (r_phase == PH_PLAIN))
        else $error("held sequence survived the end of a string");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_fin) |-> (dec.cnt != 3'd0))
        else $error("last byte of a string produced no word");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (dec.cnt <= 3'(MaxOut)))
        else $error("decoder produced too many words");

endmodule
